>>> hdl/hkm_pkg.sv
`timescale 1ns / 1ps

package hkm_pkg;

  // Number of hotkey slots that the configuration port addresses.
  localparam int unsigned SLOT_COUNT = 8;
  localparam int unsigned SLOT_W     = 3;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned FLAGS_W = 3;
  localparam int unsigned MOD_W   = 3;
  localparam int unsigned ENTRY_W = 12;

  // Modifier bits.
  localparam logic [MOD_W-1:0] MOD_NONE  = 3'b000;
  localparam logic [MOD_W-1:0] MOD_ALT   = 3'b001;
  localparam logic [MOD_W-1:0] MOD_CTRL  = 3'b010;
  localparam logic [MOD_W-1:0] MOD_SHF   = 3'b100;

  // Make codes of the modifier keys.
  localparam logic [CODE_W-1:0] SC_ALT     = 8'h38;
  localparam logic [CODE_W-1:0] SC_CTRL    = 8'h1D;
  localparam logic [CODE_W-1:0] SC_LSHIFT  = 8'h2A;
  localparam logic [CODE_W-1:0] SC_RSHIFT  = 8'h36;

  localparam logic [FLAGS_W-1:0] FLAGS_PLAIN = 3'b000;

  typedef struct packed {
    logic             valid;
    logic [MOD_W-1:0] mods;
    logic [CODE_W-1:0] code;
  } entry_t;

  // Result of evaluating one key event against the current state.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] index;
    logic [MOD_W-1:0]  mods;
  } match_res_t;

  function automatic logic [MOD_W-1:0] modifier_of(input logic [CODE_W-1:0] code);
    logic [MOD_W-1:0] m;
    m = MOD_NONE;
    unique case (code)
      SC_ALT:               m = MOD_ALT;
      SC_CTRL:              m = MOD_CTRL;
      SC_LSHIFT, SC_RSHIFT: m = MOD_SHF;
      default:              m = MOD_NONE;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/hkm_entry_regs.sv
`timescale 1ns / 1ps

module hkm_entry_regs import hkm_pkg::*; #(
  parameter int unsigned ENTRY_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [SLOT_W-1:0]   wr_index,
  input  logic [ENTRY_W-1:0]  wr_data,
  output entry_t              entries [ENTRY_COUNT]
);

  entry_t entry_r [ENTRY_COUNT];

  // Slots at or above ENTRY_COUNT are never compared, so writes to them are dropped.
  for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        entry_r[g] <= '0;
      end else if (wr_en && (wr_index == SLOT_W'(g))) begin
        entry_r[g] <= entry_t'(wr_data);
      end
    end
    assign entries[g] = entry_r[g];
  end

endmodule

>>> hdl/hkm_match.sv
`timescale 1ns / 1ps

module hkm_match import hkm_pkg::*; #(
  parameter int unsigned ENTRY_COUNT = 8
) (
  input  logic [CODE_W-1:0]  scan_code,
  input  logic [FLAGS_W-1:0] key_flags,
  input  logic [MOD_W-1:0]   mods_held,
  input  logic [SLOT_W-1:0]  last_index,
  input  entry_t             entries [ENTRY_COUNT],
  output match_res_t         res
);

  logic [MOD_W-1:0]       mod_bit;
  logic                   plain;
  logic [ENTRY_COUNT-1:0] eq;

  assign mod_bit = modifier_of(scan_code);
  assign plain   = (key_flags == FLAGS_PLAIN);

  for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cmp
    assign eq[g] = entries[g].valid && (entries[g].code == scan_code) &&
                   (entries[g].mods == mods_held);
  end

  always_comb begin
    res.hit   = 1'b0;
    res.index = last_index;
    res.mods  = mods_held;
    if (mod_bit != MOD_NONE) begin
      // Any flag other than a plain press releases the modifier.
      res.mods = plain ? (mods_held | mod_bit) : (mods_held & ~mod_bit);
    end else if (plain) begin
      // Walk downward so that the lowest matching entry wins.
      for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
        if (eq[i]) begin
          res.hit   = 1'b1;
          res.index = SLOT_W'(i);
        end
      end
    end
  end

endmodule

>>> hdl/keyboard_hotkey_matcher.sv
`timescale 1ns / 1ps
// An accepted item goes through the input register and then the result register.
// Throughput: one item per cycle while out_stall is low; an input register feeds one
// pass of compare logic (all entries side by side) that loads the result register.
// Reset (rst_n low, synchronous): both stages empty, modifier state and last match
// index zero, all hotkey entries cleared to invalid.
module keyboard_hotkey_matcher import hkm_pkg::*; #(
  parameter int unsigned ENTRY_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // Key event input.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CODE_W-1:0]   in_scan_code,
  input  logic [FLAGS_W-1:0]  in_key_flags,
  // Match result output.
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_match_hit,
  output logic [SLOT_W-1:0]   out_match_index,
  output logic [MOD_W-1:0]    out_modifier_state,
  // Hotkey table writes.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SLOT_W-1:0]   cfg_index,
  input  logic [ENTRY_W-1:0]  cfg_data
);

  // Input stage: holds one accepted event until the result register can take it.
  logic               in_vld_r;
  logic [CODE_W-1:0]  code_r;
  logic [FLAGS_W-1:0] flags_r;

  // Architectural state, updated in the same cycle that a result is loaded.
  logic [MOD_W-1:0]  mods_r;
  logic [SLOT_W-1:0] last_r;

  // Result register.
  logic       out_vld_r;
  match_res_t res_r;
  match_res_t res_nxt;

  entry_t entries [ENTRY_COUNT];

  logic out_load;
  logic in_take;

  // The result register loads a waiting event whenever it is empty or its item is leaving.
  assign out_load = in_vld_r && (!out_vld_r || !out_stall);
  // The input stage refills when it is empty or its event moves on in this cycle.
  assign in_stall = in_vld_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  // Table writes are always taken; software must write only while idle (not enforced).
  assign cfg_ready = 1'b1;

  hkm_entry_regs #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .entries  (entries)
  );

  hkm_match #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_match (
    .scan_code  (code_r),
    .key_flags  (flags_r),
    .mods_held  (mods_r),
    .last_index (last_r),
    .entries    (entries),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (out_load) begin
      in_vld_r <= 1'b0;
    end
  end

  // Payload of the input stage needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      code_r  <= in_scan_code;
      flags_r <= in_key_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r <= MOD_NONE;
      last_r <= '0;
    end else if (out_load) begin
      mods_r <= res_nxt.mods;
      last_r <= res_nxt.index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_match_hit      = res_r.hit;
  assign out_match_index    = res_r.index;
  assign out_modifier_state = res_r.mods;

endmodule

>>> hdl/hkm_checker.sv
`timescale 1ns / 1ps

module hkm_checker import hkm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_match_hit,
  input logic [SLOT_W-1:0]  out_match_index,
  input logic [MOD_W-1:0]   out_modifier_state
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // Backpressure on the input arises only from a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side can move");

  // A held result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_match_hit) &&
      $stable(out_match_index) && $stable(out_modifier_state)))
    else $error("stalled result changed");

endmodule

bind keyboard_hotkey_matcher hkm_checker u_hkm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_match_hit      (out_match_hit),
  .out_match_index    (out_match_index),
  .out_modifier_state (out_modifier_state)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hkm_pkg::*;

  // The block compares every slot in the table, so the predictor does the same.
  localparam int unsigned ENTRIES = 8;
  localparam int unsigned PHASE_EVENTS = 126;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Flag bits of a key event, beyond the plain press from the package.
  localparam logic [FLAGS_W-1:0] FLAG_BREAK = 3'b001;
  localparam logic [FLAGS_W-1:0] FLAG_E0    = 3'b010;
  localparam logic [FLAGS_W-1:0] FLAG_E1    = 3'b100;

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_e;
  typedef enum int {LOAD_HOTKEYS, LOAD_RANDOM, LOAD_EXTREMES} load_mode_e;

  // One row of the directed plan: either a key event or a hotkey table write.
  // A key event row may carry a hand-written result; otherwise the predictor
  // supplies the expectation.
  typedef struct {
    row_kind_e         kind;
    logic [CODE_W-1:0]  code;
    logic [FLAGS_W-1:0] flags;
    bit                 typed;
    match_res_t         want;
    logic [SLOT_W-1:0]  slot;
    logic [ENTRY_W-1:0] data;
  } plan_row_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CODE_W-1:0]  in_scan_code = '0;
  logic [FLAGS_W-1:0] in_key_flags = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_match_hit;
  logic [SLOT_W-1:0]  out_match_index;
  logic [MOD_W-1:0]   out_modifier_state;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [SLOT_W-1:0]  cfg_index = '0;
  logic [ENTRY_W-1:0] cfg_data = '0;

  // Predictor state: the hotkey table as written, the held modifiers and the
  // index of the latest hit.
  entry_t            hotkey_tbl [SLOT_COUNT] = '{default: '0};
  logic [MOD_W-1:0]  held_mods = MOD_NONE;
  logic [SLOT_W-1:0] last_slot = '0;

  // Results that the block owes us, oldest first.
  match_res_t pending_results [$];
  plan_row_t  plan_q [$];

  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;
  int fail_count = 0;
  int events_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int table_loads = 0;
  int cycle_count = 0;

  keyboard_hotkey_matcher u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_scan_code      (in_scan_code),
    .in_key_flags      (in_key_flags),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_match_hit     (out_match_hit),
    .out_match_index   (out_match_index),
    .out_modifier_state(out_modifier_state),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Works out what the block reports for one accepted key event and advances
  // the predicted state. Modifier keys only move the modifier bits, and any
  // nonzero flag value releases them. Other keys are only looked up on a plain
  // press, and the lowest matching slot wins.
  function automatic match_res_t score_key_event(input logic [CODE_W-1:0]  code,
                                                 input logic [FLAGS_W-1:0] flags);
    logic [MOD_W-1:0] key_bit;
    match_res_t       res;
    bit               found;
    case (code)
      SC_ALT:               key_bit = MOD_ALT;
      SC_CTRL:              key_bit = MOD_CTRL;
      SC_LSHIFT, SC_RSHIFT: key_bit = MOD_SHF;
      default:              key_bit = MOD_NONE;
    endcase
    res = '0;
    found = 1'b0;
    if (key_bit != MOD_NONE) begin
      if (flags == FLAGS_PLAIN) begin
        held_mods = held_mods | key_bit;
      end else begin
        held_mods = held_mods & ~key_bit;
      end
    end else if (flags == FLAGS_PLAIN) begin
      for (int s = 0; s < ENTRIES; s++) begin
        if (!found && hotkey_tbl[s].valid && hotkey_tbl[s].code == code &&
            hotkey_tbl[s].mods == held_mods) begin
          found = 1'b1;
          last_slot = SLOT_W'(s);
        end
      end
    end
    res.hit = found;
    res.index = last_slot;
    res.mods = held_mods;
    return res;
  endfunction

  // Scan code that sets or clears one modifier bit; either Shift key will do.
  function automatic logic [CODE_W-1:0] press_code_for(input logic [MOD_W-1:0] key_bit);
    case (key_bit)
      MOD_ALT:  return SC_ALT;
      MOD_CTRL: return SC_CTRL;
      default:  return $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
    endcase
  endfunction

  function automatic plan_row_t key_row(input logic [CODE_W-1:0]  code,
                                        input logic [FLAGS_W-1:0] flags);
    plan_row_t row;
    row = '{kind: ROW_EVENT, code: code, flags: flags, typed: 1'b0,
            want: '0, slot: '0, data: '0};
    return row;
  endfunction

  function automatic plan_row_t known_row(input logic [CODE_W-1:0]  code,
                                          input logic [FLAGS_W-1:0] flags,
                                          input logic [SLOT_W-1:0]  index,
                                          input logic [MOD_W-1:0]   mods);
    plan_row_t row;
    row = key_row(code, flags);
    row.typed = 1'b1;
    row.want = '{hit: 1'b0, index: index, mods: mods};
    return row;
  endfunction

  function automatic plan_row_t write_row(input logic [SLOT_W-1:0]  slot,
                                          input logic [ENTRY_W-1:0] data);
    plan_row_t row;
    row = key_row('0, FLAGS_PLAIN);
    row.kind = ROW_WRITE;
    row.slot = slot;
    row.data = data;
    return row;
  endfunction

  // Offers one key event and returns at the edge that accepts it. The valid
  // stays high afterwards so that back-to-back items need no second update;
  // an idle burst lowers it in the same step that the previous item went in.
  // The hand-written result, where the caller has one, replaces the
  // prediction in the queue so that it is checked independently.
  task automatic send_event(input logic [CODE_W-1:0]  code,
                            input logic [FLAGS_W-1:0] flags,
                            input bit                 typed = 1'b0,
                            input match_res_t         want = '0);
    match_res_t predicted;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_scan_code <= code;
    in_key_flags <= flags;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = score_key_event(code, flags);
    pending_results.push_back(typed ? want : predicted);
    events_sent++;
  endtask

  // Stops offering items and waits until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes one table slot. The valid is left high so that a run of writes
  // flows one per cycle; the caller lowers it after the last one.
  task automatic write_entry(input logic [SLOT_W-1:0]  slot,
                             input logic [ENTRY_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= slot;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hotkey_tbl[slot] = data;
  endtask

  // Reloads all eight slots while the block is idle. Hotkey-like slots use
  // ordinary key codes, mostly valid, with some codes repeated in a later
  // slot so that the lowest-slot-wins rule gets exercised.
  task automatic load_table(input load_mode_e mode);
    entry_t e;
    wait_drained();
    for (int s = 0; s < SLOT_COUNT; s++) begin
      e.valid = ($urandom_range(0, 7) != 0);
      e.mods = MOD_W'($urandom_range(0, 7));
      if (s > 0 && $urandom_range(0, 3) == 0) begin
        e.code = hotkey_tbl[s-1].code;
      end else begin
        e.code = CODE_W'($urandom_range(1, 88));
      end
      if (e.code == SC_ALT || e.code == SC_CTRL || e.code == SC_LSHIFT ||
          e.code == SC_RSHIFT) begin
        e.code = e.code ^ 8'h01;
      end
      if (mode == LOAD_RANDOM) begin
        e = ENTRY_W'($urandom_range(0, 4095));
      end else if (mode == LOAD_EXTREMES && s % 2 == 0) begin
        e = '1;
      end
      write_entry(SLOT_W'(s), e);
    end
    cfg_valid <= 1'b0;
    table_loads++;
  endtask

  // One random phase. Most of the traffic is a realistic hotkey chord: drop
  // the modifiers the chosen slot does not want (with any release flag),
  // press the ones it does, hit the key, and sometimes release it. The rest
  // is noise: arbitrary codes with arbitrary flags, biased toward modifiers
  // and plain presses so the modifier state keeps wandering.
  task automatic run_phase(input load_mode_e mode, input bit idle, input bit pause_once);
    int               start_count;
    bit               paused;
    entry_t           e;
    logic [MOD_W-1:0] key_bit;
    logic [CODE_W-1:0] code;
    load_table(mode);
    gaps_on = idle;
    stalls_on = idle;
    start_count = events_sent;
    paused = 1'b0;
    while (events_sent - start_count < PHASE_EVENTS) begin
      if (pause_once && !paused && events_sent - start_count > PHASE_EVENTS / 2) begin
        // Let the pipeline run completely dry once in the middle of traffic.
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        e = hotkey_tbl[$urandom_range(0, SLOT_COUNT - 1)];
        for (int b = 0; b < MOD_W; b++) begin
          key_bit = MOD_W'(1 << b);
          if ((held_mods & key_bit) != 0 && (e.mods & key_bit) == 0) begin
            send_event(press_code_for(key_bit), FLAGS_W'($urandom_range(1, 7)));
          end
        end
        for (int b = 0; b < MOD_W; b++) begin
          key_bit = MOD_W'(1 << b);
          if ((held_mods & key_bit) == 0 && (e.mods & key_bit) != 0) begin
            send_event(press_code_for(key_bit), FLAGS_PLAIN);
          end
        end
        send_event(e.code, FLAGS_PLAIN);
        if ($urandom_range(0, 1) == 1) begin
          send_event(e.code, FLAG_BREAK);
        end
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          code = press_code_for(MOD_W'(1 << $urandom_range(0, 2)));
        end else begin
          code = CODE_W'($urandom_range(0, 255));
        end
        send_event(code, $urandom_range(0, 1) ? FLAGS_PLAIN : FLAGS_W'($urandom_range(0, 7)));
      end
    end
  endtask

  // Result side: every item taken off the out_ port is compared with the
  // oldest owed result, field by field. The stall comes in random bursts
  // while stalls are enabled.
  always @(posedge clk) begin
    match_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_match_hit === 1'b1) begin
        hits_seen++;
      end
      if (pending_results.size() == 0) begin
        $error("result item with no event waiting for it");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_match_hit !== want.hit) begin
          $error("match_hit: expected %0d, got %0d", want.hit, out_match_hit);
          fail_count++;
        end
        if (out_match_index !== want.index) begin
          $error("match_index: expected %0d, got %0d", want.index, out_match_index);
          fail_count++;
        end
        if (out_modifier_state !== want.mods) begin
          $error("modifier_state: expected %0d, got %0d", want.mods, out_modifier_state);
          fail_count++;
        end
      end
    end
    if (stalls_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    // Directed plan. The first rows run against the empty table right after
    // reset, where every result is obvious. Then all eight slots are loaded
    // with hand-picked entries:
    //   slot 0: all ones, the largest value (Alt+Ctrl+Shift with code 0xFF),
    //   slots 1 and 2: the same Ctrl chord, so slot 1 must win,
    //   slot 3: a valid entry naming the Alt key itself, which never matches,
    //   slot 4: all zeros, invalid,
    //   slot 5: the Ctrl chord again but invalid,
    //   slot 6: a bare key with no modifiers,
    //   slot 7: a Shift chord.
    // The key rows after that walk press and release of every modifier with
    // break, E1 and combined release flags, both Shift keys sharing one bit, breaks and
    // prefixed presses of ordinary keys, and a miss that keeps the old index.
    plan_q.push_back(known_row(8'h00, FLAGS_PLAIN, 3'd0, MOD_NONE));
    plan_q.push_back(known_row(8'hFF, 3'b111, 3'd0, MOD_NONE));
    plan_q.push_back(known_row(SC_ALT, FLAGS_PLAIN, 3'd0, MOD_ALT));
    plan_q.push_back(known_row(SC_ALT, FLAG_E0, 3'd0, MOD_NONE));
    plan_q.push_back(write_row(3'd0, 12'hFFF));
    plan_q.push_back(write_row(3'd1, 12'hA2E));
    plan_q.push_back(write_row(3'd2, 12'hA2E));
    plan_q.push_back(write_row(3'd3, 12'h938));
    plan_q.push_back(write_row(3'd4, 12'h000));
    plan_q.push_back(write_row(3'd5, 12'h22E));
    plan_q.push_back(write_row(3'd6, 12'h83B));
    plan_q.push_back(write_row(3'd7, 12'hC01));
    plan_q.push_back(known_row(SC_CTRL, FLAGS_PLAIN, 3'd0, MOD_CTRL));
    plan_q.push_back(key_row(8'h2E, FLAGS_PLAIN));
    plan_q.push_back(key_row(8'h2E, FLAG_BREAK));
    plan_q.push_back(key_row(8'h2E, FLAG_E0));
    plan_q.push_back(key_row(SC_CTRL, FLAG_E1));
    plan_q.push_back(key_row(8'h2E, FLAGS_PLAIN));
    plan_q.push_back(key_row(SC_LSHIFT, FLAGS_PLAIN));
    plan_q.push_back(key_row(SC_RSHIFT, FLAG_BREAK));
    plan_q.push_back(key_row(SC_RSHIFT, FLAGS_PLAIN));
    plan_q.push_back(key_row(8'h01, FLAGS_PLAIN));
    plan_q.push_back(key_row(SC_ALT, FLAGS_PLAIN));
    plan_q.push_back(key_row(SC_CTRL, FLAGS_PLAIN));
    plan_q.push_back(key_row(8'hFF, FLAGS_PLAIN));
    plan_q.push_back(key_row(SC_CTRL, FLAG_BREAK));
    plan_q.push_back(key_row(SC_LSHIFT, 3'b011));
    plan_q.push_back(key_row(SC_ALT, FLAGS_PLAIN));
    plan_q.push_back(key_row(SC_ALT, 3'b111));
    plan_q.push_back(key_row(8'h3B, FLAGS_PLAIN));
    plan_q.push_back(key_row(8'h00, FLAGS_PLAIN));
    plan_q.push_back(key_row(8'h3B, FLAG_E1));

    // Synchronous reset, applied once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan_q[r]) begin
      if (plan_q[r].kind == ROW_WRITE) begin
        if (r == 0 || plan_q[r-1].kind != ROW_WRITE) begin
          wait_drained();
        end
        write_entry(plan_q[r].slot, plan_q[r].data);
      end else begin
        if (r > 0 && plan_q[r-1].kind == ROW_WRITE) begin
          cfg_valid <= 1'b0;
          table_loads++;
        end
        send_event(plan_q[r].code, plan_q[r].flags, plan_q[r].typed, plan_q[r].want);
      end
    end

    // Random phases, each starting from a freshly loaded table. The second
    // one stops mid-stream until the block is empty, the third has no idling
    // at all, and the last one runs flat out to the end.
    run_phase(LOAD_HOTKEYS, 1'b1, 1'b0);
    run_phase(LOAD_RANDOM, 1'b1, 1'b1);
    run_phase(LOAD_HOTKEYS, 1'b0, 1'b0);
    run_phase(LOAD_EXTREMES, 1'b1, 1'b0);
    run_phase(LOAD_HOTKEYS, 1'b0, 1'b0);

    // Drain, then keep watching the two-stage pipeline in case the block
    // produces anything it does not owe.
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Covered %0d key events across %0d table loads; %0d results compared, %0d hits.",
             events_sent, table_loads, results_seen, hits_seen);
    $display("Field mismatches and unexpected results: %0d.", fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
